// ===== rtl/ssr_pkg.sv =====
// Shared types and constants for the servo status packet receiver.
// No dependencies; every other file refers to it by scoped names.
package ssr_pkg;

	localparam int unsigned IDX_W   = 9;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ACCEPT  = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// packet positions
	localparam logic [IDX_W-1:0] IDX_ID     = 9'd2;
	localparam logic [IDX_W-1:0] IDX_LENGTH = 9'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] byte_out;
		logic              checksum_ok;
		logic [BYTE_W-1:0] length_byte;
	} res_t;

	// handshake from the core into the output buffer
	typedef struct packed {
		logic push;
	} buf_ctrl_t;

endpackage

// ===== rtl/ssr_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on ssr_pkg for field widths.
interface ssr_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic [ssr_pkg::BYTE_W-1:0] byte_value;

	modport source (output valid, output command, output byte_value, input ready);
	modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface ssr_res_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [ssr_pkg::IDX_W-1:0]  byte_index;
	logic [ssr_pkg::BYTE_W-1:0] byte_out;
	logic                       checksum_ok;
	logic [ssr_pkg::BYTE_W-1:0] length_byte;

	modport source (output valid, output kind, output byte_index, output byte_out,
		output checksum_ok, output length_byte, input ready);
	modport sink   (input valid, input kind, input byte_index, input byte_out,
		input checksum_ok, input length_byte, output ready);
endinterface

// ===== rtl/servo_status_packet_receiver.sv =====
// Servo bus status packet receiver: input register, packet core, output buffer.
// One command word per cycle while the output buffer has room; each result word
// passes from the input register via the packet core to the output register, or
// to the skid register while results stall. Throughput is set by the packet state
// update. arst_n clears all control state, limit back to 1000 ticks.
// Depends on ssr_pkg, ssr_if, ssr_core and ssr_out_buf.
module servo_status_packet_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ssr_pkg::TICK_W-1:0] cfg_wdata,
	ssr_cmd_if.sink                    item,
	ssr_res_if.source                  result
);

	logic                       valid_s1;
	logic [1:0]                 command_s1;
	logic [ssr_pkg::BYTE_W-1:0] byte_s1;
	logic                       full;
	logic                       push;
	logic                       accept;
	ssr_pkg::res_t              push_data;
	ssr_pkg::buf_ctrl_t         buf_ctrl;

	assign item.ready = !valid_s1 || !full;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= item.command;
			byte_s1    <= item.byte_value;
		end
	end

	ssr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.valid_s1   (valid_s1),
		.command_s1 (command_s1),
		.byte_s1    (byte_s1),
		.full       (full),
		.push       (push),
		.push_data  (push_data)
	);

	always_comb begin
		buf_ctrl.push = push;
	end

	ssr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_in   (buf_ctrl),
		.full      (full),
		.push_data (push_data),
		.result    (result)
	);

endmodule

// ===== rtl/ssr_core.sv =====
// Packet state and result computation for one registered command word.
// Depends on ssr_pkg.
module ssr_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ssr_pkg::TICK_W-1:0] cfg_wdata,
	input  logic                       valid_s1,
	input  logic [1:0]                 command_s1,
	input  logic [ssr_pkg::BYTE_W-1:0] byte_s1,
	input  logic                       full,
	output logic                       push,
	output ssr_pkg::res_t              push_data
);

	logic [ssr_pkg::TICK_W-1:0] timeout_q;
	logic                       active_q;
	logic [ssr_pkg::IDX_W-1:0]  byte_count_q;
	logic [ssr_pkg::BYTE_W-1:0] length_q;
	logic [ssr_pkg::BYTE_W-1:0] sum_q;
	logic [ssr_pkg::TICK_W-1:0] idle_q;

	logic                       adv;
	logic                       is_byte;
	logic                       is_tick;
	logic [ssr_pkg::BYTE_W-1:0] sum_nx;
	logic [ssr_pkg::BYTE_W-1:0] len_nx;
	logic [ssr_pkg::BYTE_W-1:0] sum_chk;
	logic                       done;
	logic [ssr_pkg::TICK_W-1:0] idle_inc;
	logic                       timed_out;

	assign adv     = valid_s1 && !full;
	assign is_byte = active_q && (command_s1 == ssr_pkg::CMD_BYTE);
	assign is_tick = active_q && (command_s1 == ssr_pkg::CMD_TICK);

	always_comb begin
		sum_nx   = (byte_count_q >= ssr_pkg::IDX_ID) ? sum_q + byte_s1 : sum_q;
		len_nx   = (byte_count_q == ssr_pkg::IDX_LENGTH) ? byte_s1 : length_q;
		sum_chk  = sum_nx + 8'd1;
		done     = (byte_count_q >= ssr_pkg::IDX_LENGTH) &&
			(byte_count_q == ({1'b0, len_nx} + ssr_pkg::IDX_LENGTH));
		idle_inc = (idle_q == ssr_pkg::TICK_MAX) ? idle_q : idle_q + 16'd1;
		timed_out = (idle_inc >= timeout_q);
	end

	always_comb begin
		push      = adv && (is_byte || (is_tick && timed_out));
		push_data = '0;
		if (is_byte) begin
			push_data.kind          = done ? ssr_pkg::KIND_DONE : ssr_pkg::KIND_ACCEPT;
			push_data.byte_index    = byte_count_q;
			push_data.byte_out      = byte_s1;
			push_data.checksum_ok   = done && (sum_chk == 8'd0);
			push_data.length_byte   = len_nx;
		end else begin
			push_data.kind          = ssr_pkg::KIND_TIMEOUT;
			push_data.byte_index    = byte_count_q;
			push_data.length_byte   = length_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= ssr_pkg::TIMEOUT_RESET;
			active_q     <= 1'b0;
			byte_count_q <= '0;
			length_q     <= '0;
			sum_q        <= '0;
			idle_q       <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (adv) begin
				if (command_s1 == ssr_pkg::CMD_START) begin
					active_q     <= 1'b1;
					byte_count_q <= '0;
					length_q     <= '0;
					sum_q        <= '0;
					idle_q       <= '0;
				end else if (is_byte) begin
					idle_q   <= '0;
					sum_q    <= sum_nx;
					length_q <= len_nx;
					if (done) begin
						active_q <= 1'b0;
					end else begin
						byte_count_q <= byte_count_q + 9'd1;
					end
				end else if (is_tick) begin
					idle_q <= idle_inc;
					if (timed_out) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/ssr_out_buf.sv =====
// Two-word output buffer: result register plus skid register.
// Depends on ssr_pkg; drives the result channel.
module ssr_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  ssr_pkg::buf_ctrl_t ctrl_in,
	output logic               full,
	input  ssr_pkg::res_t      push_data,
	ssr_res_if.source          result
);

	ssr_pkg::res_t out_q;
	ssr_pkg::res_t skid_q;
	logic          out_valid_q;
	logic          skid_valid_q;
	logic          load_out;

	// output register free or draining this cycle
	assign load_out = !out_valid_q || result.ready;
	assign full     = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= ctrl_in.push;
			end
		end else if (ctrl_in.push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (ctrl_in.push) begin
				out_q <= push_data;
			end
		end else if (ctrl_in.push) begin
			skid_q <= push_data;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_q.kind;
	assign result.byte_index    = out_q.byte_index;
	assign result.byte_out      = out_q.byte_out;
	assign result.checksum_ok   = out_q.checksum_ok;
	assign result.length_byte   = out_q.length_byte;

endmodule

// ===== tb/servo_status_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for servo_status_packet_receiver: a directed table, then random
// status packets under several timeout limits, checked against a packet model of its own.
// Depends on ssr_pkg, ssr_if and the receiver RTL.
module servo_status_packet_receiver_tb;

	localparam int unsigned BYTE_W = ssr_pkg::BYTE_W;
	localparam int unsigned IDX_W  = ssr_pkg::IDX_W;
	localparam int unsigned TICK_W = ssr_pkg::TICK_W;

	localparam logic [1:0] CMD_START    = ssr_pkg::CMD_START;
	localparam logic [1:0] CMD_BYTE     = ssr_pkg::CMD_BYTE;
	localparam logic [1:0] CMD_TICK     = ssr_pkg::CMD_TICK;
	localparam logic [1:0] KIND_ACCEPT  = ssr_pkg::KIND_ACCEPT;
	localparam logic [1:0] KIND_DONE    = ssr_pkg::KIND_DONE;
	localparam logic [1:0] KIND_TIMEOUT = ssr_pkg::KIND_TIMEOUT;

	localparam logic [IDX_W-1:0]  IDX_ID        = ssr_pkg::IDX_ID;
	localparam logic [IDX_W-1:0]  IDX_LENGTH    = ssr_pkg::IDX_LENGTH;
	localparam logic [TICK_W-1:0] TICK_MAX      = ssr_pkg::TICK_MAX;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = ssr_pkg::TIMEOUT_RESET;

	typedef ssr_pkg::res_t res_t;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LATENCY_PAD     = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 2000;
	localparam int WORDS_PER_PHASE = 45;
	localparam int N_PHASES        = 5;
	localparam int RESET_TICKS     = 8;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [BYTE_W-1:0] val;
		logic              typed;
		logic              has_res;
		res_t              res;
	} row_t;

	localparam res_t NO_RES = '0;
	localparam int N_ROWS = 25;
	localparam row_t DIRECTED [N_ROWS] = '{
		'{CMD_BYTE,   8'h55, 1'b1, 1'b0, NO_RES},
		'{CMD_TICK,   8'h00, 1'b1, 1'b0, NO_RES},
		'{CMD_UNUSED, 8'hAA, 1'b1, 1'b0, NO_RES},
		'{CMD_START,  8'h00, 1'b1, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hFF, 1'b1, 1'b1, '{KIND_ACCEPT, 9'd0, 8'hFF, 1'b0, 8'd0}},
		'{CMD_BYTE,   8'h00, 1'b1, 1'b1, '{KIND_ACCEPT, 9'd1, 8'h00, 1'b0, 8'd0}},
		'{CMD_BYTE,   8'hFF, 1'b1, 1'b1, '{KIND_ACCEPT, 9'd2, 8'hFF, 1'b0, 8'd0}},
		// zero length: the length byte closes the packet, id FF makes the sum good
		'{CMD_BYTE,   8'h00, 1'b1, 1'b1, '{KIND_DONE,   9'd3, 8'h00, 1'b1, 8'd0}},
		'{CMD_BYTE,   8'h12, 1'b1, 1'b0, NO_RES},
		'{CMD_START,  8'hFF, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hFF, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hFF, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'h01, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'h02, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'h00, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hFD, 1'b0, 1'b0, NO_RES},
		'{CMD_START,  8'h00, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hAA, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hBB, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'h07, 1'b0, 1'b0, NO_RES},
		'{CMD_BYTE,   8'hFF, 1'b0, 1'b0, NO_RES},
		'{CMD_TICK,   8'h00, 1'b0, 1'b0, NO_RES},
		// restart while a packet is under way
		'{CMD_START,  8'h00, 1'b1, 1'b0, NO_RES},
		'{CMD_BYTE,   8'h01, 1'b1, 1'b1, '{KIND_ACCEPT, 9'd0, 8'h01, 1'b0, 8'd0}},
		'{CMD_BYTE,   8'h80, 1'b0, 1'b0, NO_RES}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [TICK_W-1:0] cfg_wdata;

	ssr_cmd_if item_if ();
	ssr_res_if res_if ();

	servo_status_packet_receiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_if),
		.result    (res_if)
	);

	always #5 clk = ~clk;

	// packet model state
	bit                pkt_active;
	logic [IDX_W-1:0]  pkt_count;
	logic [BYTE_W-1:0] pkt_len;
	logic [BYTE_W-1:0] pkt_sum;
	logic [TICK_W-1:0] pkt_idle;
	logic [TICK_W-1:0] limit_ticks;

	res_t pending_results [$];
	res_t exp_r;
	res_t got_r;

	bit calm;
	bit hold_req;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;
	int errors = 0;
	int n_words;
	int n_results = 0;
	int n_done = 0;
	int n_badsum = 0;
	int n_timeout = 0;

	task automatic receiver_step(input logic [1:0] cmd, input logic [BYTE_W-1:0] val,
		output bit hit, output res_t r);
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] sum1;
		hit = 1'b0;
		r = '0;
		if (cmd == CMD_START) begin
			pkt_active = 1'b1;
			pkt_count = '0;
			pkt_len = '0;
			pkt_sum = '0;
			pkt_idle = '0;
		end else if (pkt_active && cmd == CMD_BYTE) begin
			idx = pkt_count;
			pkt_idle = '0;
			if (idx >= IDX_ID)
				pkt_sum = pkt_sum + val;
			if (idx == IDX_LENGTH)
				pkt_len = val;
			hit = 1'b1;
			r.byte_index = idx;
			r.byte_out = val;
			r.length_byte = pkt_len;
			if (idx >= IDX_LENGTH && idx == {1'b0, pkt_len} + IDX_LENGTH) begin
				sum1 = pkt_sum + 8'd1;
				r.kind = KIND_DONE;
				r.checksum_ok = (sum1 == 8'd0);
				pkt_active = 1'b0;
			end else begin
				r.kind = KIND_ACCEPT;
				pkt_count = idx + 1'b1;
			end
		end else if (pkt_active && cmd == CMD_TICK) begin
			if (pkt_idle != TICK_MAX)
				pkt_idle = pkt_idle + 1'b1;
			if (pkt_idle >= limit_ticks) begin
				hit = 1'b1;
				r.kind = KIND_TIMEOUT;
				r.byte_index = pkt_count;
				r.length_byte = pkt_len;
				pkt_active = 1'b0;
			end
		end
	endtask

	task automatic send_word(input logic [1:0] cmd, input logic [BYTE_W-1:0] val,
		input bit typed = 1'b0, input bit typed_has = 1'b0, input res_t typed_res = '0);
		bit   hit;
		res_t r;
		while (!calm && $urandom_range(0, 99) < 11) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.command <= cmd;
		item_if.byte_value <= val;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		receiver_step(cmd, val, hit, r);
		if (typed) begin
			hit = typed_has;
			r = typed_res;
		end
		if (hit)
			pending_results.push_back(r);
		n_words++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_word(CMD_TICK, 8'($urandom));
	endtask

	// hold the input idle until every expected word is in, then let the pipe empty
	task automatic settle();
		item_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [TICK_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_ticks = v;
	endtask

	function automatic int safe_gap();
		return (limit_ticks > 4) ? 3 : int'(limit_ticks) - 1;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 6);
		else if (r < 97)
			return $urandom_range(7, 24);
		return $urandom_range(25, 60);
	endfunction

	task automatic maybe_gap(input int gap_max);
		if ($urandom_range(0, 99) < 20)
			send_ticks($urandom_range(0, gap_max));
	endtask

	task automatic send_packet(input int len, input bit good, input int gap_max);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		int                i;
		send_word(CMD_START, 8'($urandom));
		repeat (2)
			send_word(CMD_BYTE, ($urandom_range(0, 9) != 0) ? 8'hFF : 8'($urandom));
		b = (len == 0 && good) ? 8'hFF : 8'($urandom);
		sum = b;
		send_word(CMD_BYTE, b);
		maybe_gap(gap_max);
		sum = sum + 8'(len);
		send_word(CMD_BYTE, 8'(len));
		if (len > 0) begin
			maybe_gap(gap_max);
			for (i = 4; i < len + 3; i++) begin
				b = 8'($urandom);
				sum = sum + b;
				send_word(CMD_BYTE, b);
				maybe_gap(gap_max);
			end
			send_word(CMD_BYTE, good ? ~sum : 8'($urandom));
		end
	endtask

	task automatic random_sequence();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			send_packet(pick_len(), $urandom_range(0, 3) != 0, safe_gap());
		end else if (r < 77) begin
			// cut short, then left to time out where the limit is small enough
			send_word(CMD_START, 8'($urandom));
			repeat ($urandom_range(0, 6))
				send_word(CMD_BYTE, 8'($urandom));
			send_ticks((limit_ticks <= 64) ? int'(limit_ticks) : $urandom_range(1, 5));
		end else if (r < 87) begin
			send_word(CMD_START, 8'($urandom));
			repeat ($urandom_range(1, 5))
				send_word(CMD_BYTE, 8'($urandom));
			send_packet(pick_len(), 1'b1, safe_gap());
		end else if (r < 92) begin
			send_packet(pick_len(), 1'b1, (limit_ticks <= 64) ? int'(limit_ticks) : 3);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n)
				send_word(2'($urandom_range(0, 3)), 8'($urandom));
		end
	endtask

	// result side: random ready, one long hold-off, and the check
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				got_r = '{res_if.kind, res_if.byte_index, res_if.byte_out,
					res_if.checksum_ok, res_if.length_byte};
				n_results++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected: kind %0d index %0d byte %0h",
						$time, got_r.kind, got_r.byte_index, got_r.byte_out);
				end else begin
					exp_r = pending_results.pop_front();
					if (exp_r.kind == KIND_DONE) begin
						n_done++;
						if (!exp_r.checksum_ok)
							n_badsum++;
					end
					if (exp_r.kind == KIND_TIMEOUT)
						n_timeout++;
					if (got_r !== exp_r) begin
						errors++;
						$display("%0t: mismatch: expected kind %0d idx %0d byte %0h ok %0b len %0d",
							$time, exp_r.kind, exp_r.byte_index, exp_r.byte_out,
							exp_r.checksum_ok, exp_r.length_byte);
						$display("%0t:           actual kind %0d idx %0d byte %0h ok %0b len %0d",
							$time, got_r.kind, got_r.byte_index, got_r.byte_out,
							got_r.checksum_ok, got_r.length_byte);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_if.ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= calm || ($urandom_range(0, 99) >= 11);
			end
		end else begin
			res_if.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
			stall_cycles <= 0;
		else if (arst_n)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("** servo_status_packet_receiver: FAILED **");
			$finish;
		end
	end

	initial begin
		int i;
		int phase;
		int phase_end;
		logic [TICK_W-1:0] lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_if.valid = 1'b0;
		item_if.command = CMD_START;
		item_if.byte_value = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		n_words = 0;
		limit_ticks = TIMEOUT_RESET;
		pkt_active = 1'b0;
		pkt_count = '0;
		pkt_len = '0;
		pkt_sum = '0;
		pkt_idle = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++)
			send_word(DIRECTED[i].cmd, DIRECTED[i].val, DIRECTED[i].typed,
				DIRECTED[i].has_res, DIRECTED[i].res);

		// reset limit: a short run of ticks leaves the packet open
		send_word(CMD_BYTE, 8'h33);
		send_ticks(RESET_TICKS);

		for (phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: lim = 16'd1;
				1: lim = TICK_MAX;
				2: lim = 16'($urandom_range(2, 12));
				3: lim = 16'($urandom_range(13, 60));
				default: lim = 16'($urandom_range(61, 2000));
			endcase
			write_limit(lim);
			calm <= (phase == 3);
			if (phase == 2) begin
				// longest packet while the result side holds off
				hold_req <= 1'b1;
				send_packet(255, 1'b1, 0);
			end
			phase_end = n_words + WORDS_PER_PHASE;
			while (n_words < phase_end)
				random_sequence();
		end

		settle();
		$display("Sent %0d command words under limits 1, 1000, 65535 and random; %0d results",
			n_words, n_results);
		$display("seen: %0d packets complete (%0d bad checksum), %0d timeouts",
			n_done, n_badsum, n_timeout);
		if (errors == 0 && pending_results.size() == 0)
			$display("** servo_status_packet_receiver: PASSED **");
		else
			$display("** servo_status_packet_receiver: FAILED **");
		$finish;
	end

endmodule

// ===== servo_status_packet_receiver.f =====
rtl/ssr_pkg.sv
rtl/ssr_if.sv
rtl/ssr_core.sv
rtl/ssr_out_buf.sv
rtl/servo_status_packet_receiver.sv
tb/servo_status_packet_receiver_tb.sv
